// File: design/lcst_pkg.sv
// shared types, constants and codes of the li chao segment max tree unit
package lcst_pkg;

    localparam int X_BITS      = 10;
    localparam int ADDR_W      = X_BITS + 1;
    localparam int NODES       = 1 << ADDR_W;
    localparam int STACK_DEPTH = X_BITS;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SL_W        = 32;
    localparam int OFF_W       = 48;
    localparam int EV_W        = 47;
    localparam int VAL_W       = 49;

    localparam logic [X_BITS-1:0] MAX_X = {X_BITS{1'b1}};

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic CFG_FIND_MAX = 1'b0;
    localparam logic CFG_EMPTY    = 1'b1;

    typedef struct packed {
        logic                    present;
        logic signed [SL_W-1:0]  slope;
        logic signed [OFF_W-1:0] offset;
    } node_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_WT,
        S_EL,
        S_ER,
        S_EM,
        S_DEC,
        S_QRD,
        S_QWT,
        S_QEV,
        S_QFIN
    } state_t;

endpackage

// File: design/lcst_node_ram.sv
// node line store: one write port, one registered read port
module lcst_node_ram
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [lcst_pkg::ADDR_W-1:0]  waddr,
    input  lcst_pkg::node_t              wdata,
    input  logic                         re,
    input  logic [lcst_pkg::ADDR_W-1:0]  raddr,
    output lcst_pkg::node_t              rdata
);
    import lcst_pkg::*;

    node_t mem [NODES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/lcst_line_eval.sv
// evaluates one line slope*x+offset at a point
module lcst_line_eval
(
    input  logic signed [lcst_pkg::SL_W-1:0]  slope,
    input  logic signed [lcst_pkg::OFF_W-1:0] offset,
    input  logic        [lcst_pkg::X_BITS-1:0] x,
    output logic signed [lcst_pkg::VAL_W-1:0] value
);
    import lcst_pkg::*;

    logic signed [SL_W+X_BITS:0] prod;

    assign prod  = slope * $signed({1'b0, x});
    assign value = VAL_W'(prod) + VAL_W'(offset);

endmodule

// File: design/li_chao_segment_max_tree_unit.sv
// top level: command sequencer of the li chao segment max tree unit
//
// input channel (in_valid/in_ready) takes one command per beat: add a line
// over seg_lo..seg_hi, query a point, or clear the tree. only a query
// returns a beat on the output channel (out_valid/out_ready, best_value).
// config channel (cfg_valid/cfg_ready) is always ready; index 0 is
// find_max, index 1 is empty_value.
// a query walks from the root toward a leaf with a read, a wait and an
// evaluation per level, and stops early at the first empty node. an add
// visits each node with a read and a wait when only split or out of span,
// and with a read, three paired line evaluations and a write when covered;
// the root may keep the line, a split span takes about 40 node visits, and
// covered nodes may push lines down to the leaves.
// the node memory's single read port sets the pace of these walks.
// clear sweeps the node memory, one entry a cycle, leaving only the root
// with the empty line; the same sweep runs after reset.
// in_ready is low while a command or a sweep is in progress. a finished
// query result waits in the output register while the next command is
// accepted; a second result waits until the first beat is taken.
module li_chao_segment_max_tree_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          cmd,
    input  logic signed [lcst_pkg::SL_W-1:0]    slope,
    input  logic signed [31:0]                  intercept,
    input  logic [lcst_pkg::X_BITS-1:0]         seg_lo,
    input  logic [lcst_pkg::X_BITS-1:0]         seg_hi,
    input  logic [lcst_pkg::X_BITS-1:0]         point,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [lcst_pkg::VAL_W-1:0]   best_value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [lcst_pkg::EV_W-1:0]           cfg_data
);
    import lcst_pkg::*;

    state_t state_reg, state_next;

    logic                    find_max_reg;
    logic signed [EV_W-1:0]  empty_reg;
    logic [ADDR_W-1:0]       clr_addr_reg, clr_addr_next;

    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic [X_BITS-1:0]       l_reg, l_next, r_reg, r_next;
    logic [X_BITS-1:0]       lo_reg, lo_next, hi_reg, hi_next, qx_reg, qx_next;
    logic signed [SL_W-1:0]  in_sl_reg, in_sl_next, new_sl_reg, new_sl_next;
    logic signed [OFF_W-1:0] in_off_reg, in_off_next, new_off_reg, new_off_next;
    logic signed [SL_W-1:0]  cur_sl_reg, cur_sl_next;
    logic signed [OFF_W-1:0] cur_off_reg, cur_off_next;
    logic signed [VAL_W-1:0] cl_reg, nl_reg, cr_reg, nr_reg, cm_reg, nm_reg;
    logic signed [VAL_W-1:0] res_reg, res_next;
    logic                    res_ok_reg, res_ok_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] out_reg, out_next;

    logic [SP_W-1:0]         sp_reg, sp_next;
    logic [ADDR_W-1:0]       stk_idx_reg [STACK_DEPTH];
    logic [X_BITS-1:0]       stk_l_reg [STACK_DEPTH];
    logic [X_BITS-1:0]       stk_r_reg [STACK_DEPTH];
    logic                    push;

    logic                    ram_we, ram_re;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    node_t                   ram_wdata, ram_rdata;

    logic [X_BITS-1:0]       ev_x;
    logic signed [VAL_W-1:0] cur_v, new_v;
    logic signed [OFF_W-1:0] empty_off;
    logic [X_BITS:0]         lr_sum;
    logic [X_BITS-1:0]       mid;
    logic                    in_acc, out_free;
    logic                    is_out, is_cov, swap;
    logic                    keep_here, go_right;
    logic signed [SL_W-1:0]  a_sl, c_sl;
    logic signed [OFF_W-1:0] a_off, c_off;
    logic signed [VAL_W-1:0] av_r, cv_r, av_m, cv_m, res_cand;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == S_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign best_value = out_reg;
    assign out_free   = !out_valid_reg || out_ready;

    assign empty_off = find_max_reg ? OFF_W'(empty_reg) : -OFF_W'(empty_reg);
    assign lr_sum    = {1'b0, l_reg} + {1'b0, r_reg};
    assign mid       = lr_sum[X_BITS:1];
    assign is_out    = (hi_reg < l_reg) || (r_reg < lo_reg);
    assign is_cov    = (lo_reg <= l_reg) && (r_reg <= hi_reg);

    assign swap  = cl_reg >= nl_reg;
    assign a_sl  = swap ? cur_sl_reg : new_sl_reg;
    assign a_off = swap ? cur_off_reg : new_off_reg;
    assign c_sl  = swap ? new_sl_reg : cur_sl_reg;
    assign c_off = swap ? new_off_reg : cur_off_reg;
    assign av_r  = swap ? cr_reg : nr_reg;
    assign cv_r  = swap ? nr_reg : cr_reg;
    assign av_m  = swap ? cm_reg : nm_reg;
    assign cv_m  = swap ? nm_reg : cm_reg;
    assign keep_here = cv_r <= av_r;
    assign go_right  = av_m >= cv_m;
    assign res_cand  = (!res_ok_reg || cur_v > res_reg) ? cur_v : res_reg;

    always_comb
    begin
        case (state_reg)
            S_EL:    ev_x = l_reg;
            S_ER:    ev_x = r_reg;
            S_EM:    ev_x = mid;
            default: ev_x = qx_reg;
        endcase
    end

    lcst_line_eval u_eval_cur
    (
        .slope  (cur_sl_reg),
        .offset (cur_off_reg),
        .x      (ev_x),
        .value  (cur_v)
    );

    lcst_line_eval u_eval_new
    (
        .slope  (new_sl_reg),
        .offset (new_off_reg),
        .x      (ev_x),
        .value  (new_v)
    );

    lcst_node_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (clr_addr_reg == ADDR_W'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (cmd == CMD_ADD && seg_lo <= seg_hi)
                    begin
                        state_next = S_RD;
                    end
                    else if (cmd == CMD_QUERY)
                    begin
                        state_next = S_QRD;
                    end
                    else if (cmd == CMD_CLEAR)
                    begin
                        state_next = S_CLR;
                    end
                end
            end
            S_RD:  state_next = S_WT;
            S_WT:
            begin
                if (is_out)
                begin
                    state_next = (sp_reg == '0) ? S_IDLE : S_RD;
                end
                else if (is_cov)
                begin
                    state_next = S_EL;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_EL:  state_next = S_ER;
            S_ER:  state_next = S_EM;
            S_EM:  state_next = S_DEC;
            S_DEC:
            begin
                if (keep_here)
                begin
                    state_next = (sp_reg == '0) ? S_IDLE : S_RD;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_QRD: state_next = S_QWT;
            S_QWT: state_next = ram_rdata.present ? S_QEV : S_QFIN;
            S_QEV: state_next = idx_reg[X_BITS] ? S_QFIN : S_QRD;
            S_QFIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        idx_next       = idx_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        qx_next        = qx_reg;
        in_sl_next     = in_sl_reg;
        in_off_next    = in_off_reg;
        new_sl_next    = new_sl_reg;
        new_off_next   = new_off_reg;
        cur_sl_next    = cur_sl_reg;
        cur_off_next   = cur_off_reg;
        res_next       = res_reg;
        res_ok_next    = res_ok_reg;
        sp_next        = sp_reg;
        push           = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = '{present: 1'b1, slope: '0, offset: empty_off};
        ram_re         = 1'b0;
        ram_raddr      = idx_reg;

        case (state_reg)
            S_CLR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '{present: (clr_addr_reg == ADDR_W'(1)),
                                  slope: '0, offset: empty_off};
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            S_IDLE:
            begin
                clr_addr_next = '0;
                idx_next      = ADDR_W'(1);
                l_next        = '0;
                r_next        = MAX_X;
                lo_next       = seg_lo;
                hi_next       = seg_hi;
                qx_next       = point;
                sp_next       = '0;
                res_ok_next   = 1'b0;
                if (find_max_reg)
                begin
                    in_sl_next  = slope;
                    in_off_next = OFF_W'(intercept);
                end
                else
                begin
                    in_sl_next  = -slope;
                    in_off_next = -OFF_W'(intercept);
                end
                new_sl_next  = in_sl_next;
                new_off_next = in_off_next;
            end
            S_RD:
            begin
                ram_re = 1'b1;
            end
            S_WT:
            begin
                if (ram_rdata.present)
                begin
                    cur_sl_next  = ram_rdata.slope;
                    cur_off_next = ram_rdata.offset;
                end
                else
                begin
                    ram_we       = 1'b1;
                    cur_sl_next  = '0;
                    cur_off_next = empty_off;
                end
                if (is_out)
                begin
                    if (sp_reg != '0)
                    begin
                        sp_next      = sp_reg - SP_W'(1);
                        idx_next     = stk_idx_reg[sp_next];
                        l_next       = stk_l_reg[sp_next];
                        r_next       = stk_r_reg[sp_next];
                        new_sl_next  = in_sl_reg;
                        new_off_next = in_off_reg;
                    end
                end
                else if (!is_cov)
                begin
                    push     = 1'b1;
                    sp_next  = sp_reg + SP_W'(1);
                    idx_next = {idx_reg[ADDR_W-2:0], 1'b0};
                    r_next   = mid;
                end
            end
            S_EL:
            begin
            end
            S_ER:
            begin
            end
            S_EM:
            begin
            end
            S_DEC:
            begin
                ram_we = 1'b1;
                if (keep_here)
                begin
                    ram_wdata = '{present: 1'b1, slope: a_sl, offset: a_off};
                    if (sp_reg != '0)
                    begin
                        sp_next      = sp_reg - SP_W'(1);
                        idx_next     = stk_idx_reg[sp_next];
                        l_next       = stk_l_reg[sp_next];
                        r_next       = stk_r_reg[sp_next];
                        new_sl_next  = in_sl_reg;
                        new_off_next = in_off_reg;
                    end
                end
                else if (go_right)
                begin
                    ram_wdata    = '{present: 1'b1, slope: a_sl, offset: a_off};
                    new_sl_next  = c_sl;
                    new_off_next = c_off;
                    idx_next     = {idx_reg[ADDR_W-2:0], 1'b1};
                    l_next       = mid + X_BITS'(1);
                end
                else
                begin
                    ram_wdata    = '{present: 1'b1, slope: c_sl, offset: c_off};
                    new_sl_next  = a_sl;
                    new_off_next = a_off;
                    idx_next     = {idx_reg[ADDR_W-2:0], 1'b0};
                    r_next       = mid;
                end
            end
            S_QRD:
            begin
                ram_re = 1'b1;
            end
            S_QWT:
            begin
                cur_sl_next  = ram_rdata.slope;
                cur_off_next = ram_rdata.offset;
            end
            S_QEV:
            begin
                res_next    = res_cand;
                res_ok_next = 1'b1;
                if (qx_reg <= mid)
                begin
                    idx_next = {idx_reg[ADDR_W-2:0], 1'b0};
                    r_next   = mid;
                end
                else
                begin
                    idx_next = {idx_reg[ADDR_W-2:0], 1'b1};
                    l_next   = mid + X_BITS'(1);
                end
            end
            S_QFIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = find_max_reg ? res_reg : -res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_addr_reg  <= '0;
            sp_reg        <= '0;
            res_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            find_max_reg  <= 1'b1;
            empty_reg     <= {1'b1, {(EV_W-1){1'b0}}};
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            sp_reg        <= sp_next;
            res_ok_reg    <= res_ok_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FIND_MAX)
                begin
                    find_max_reg <= cfg_data[0];
                end
                else if (cfg_index == CFG_EMPTY)
                begin
                    empty_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        qx_reg      <= qx_next;
        in_sl_reg   <= in_sl_next;
        in_off_reg  <= in_off_next;
        new_sl_reg  <= new_sl_next;
        new_off_reg <= new_off_next;
        cur_sl_reg  <= cur_sl_next;
        cur_off_reg <= cur_off_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        if (state_reg == S_EL)
        begin
            cl_reg <= cur_v;
            nl_reg <= new_v;
        end
        if (state_reg == S_ER)
        begin
            cr_reg <= cur_v;
            nr_reg <= new_v;
        end
        if (state_reg == S_EM)
        begin
            cm_reg <= cur_v;
            nm_reg <= new_v;
        end
        // right child waits on the stack while the left one is walked
        if (push)
        begin
            stk_idx_reg[sp_reg] <= {idx_reg[ADDR_W-2:0], 1'b1};
            stk_l_reg[sp_reg]   <= mid + X_BITS'(1);
            stk_r_reg[sp_reg]   <= r_reg;
        end
    end

`ifndef SYNTH
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("node stack overflow");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !ram_we)
        else $error("node memory written while idle");

    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_QFIN))
        else $error("result raised outside query finish");

    a_push_only_split: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (state_reg == S_WT) && !is_cov && !is_out)
        else $error("stack push outside a split node");
`endif

endmodule
